### rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and constants for the circular buffer deque: command codes,
// the input and result item structs, and the controller state type.
// ----------------------------------------------------------------------------
package cbd_pkg;

    // Fixed field widths of the item interface.
    localparam int CMD_W  = 3;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 6;

    // Capacity register value after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd6;

    // One input item.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] data_in;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] data_out;
        logic [CNT_W-1:0]  fill_count;
        logic              is_empty;
        logic              is_full;
    } t_out_item;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } t_state;

endpackage

### rtl/circular_buffer_deque.sv
// ----------------------------------------------------------------------------
// circular_buffer_deque
// Double-ended queue kept in a circular buffer of RAM slots, with head and
// tail indices and an entry count. Supports push, pop and peek at either end
// and a front-to-rear search for a key.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-----------------------
//  in       | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (capacity)
//
// Push and every failing command register their result at accept. Pop and
// peek issue the slot read at accept and register the result in ST_READ,
// after the registered read of the slot RAM. A search reads one slot per
// cycle through the RAM read port and stops at the first match. Reset is
// synchronous and needs no clearing pass. A result waits in the output
// register while the block takes the next item, as long as it is taken by then.
// ----------------------------------------------------------------------------
module circular_buffer_deque #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cbd_pkg::t_in_item     i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cbd_pkg::t_out_item    o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [cbd_pkg::CNT_W-1:0] i_cfg_data
);

    import cbd_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int W  = ((IW > CNT_W) ? IW : CNT_W) + 1;

    // Control registers.
    t_state               r_state, n_state;
    logic [IW-1:0]        r_head, n_head;
    logic [IW-1:0]        r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_cap, n_cap;
    logic [IW-1:0]        r_scan_idx, n_scan_idx;
    logic [CNT_W-1:0]     r_scan_left, n_scan_left;
    logic                 r_pend, n_pend;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    // RAM ports.
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [WORD_W-1:0]     rd_word;

    // Datapath helpers.
    logic [W-1:0]  cap_w;
    logic          is_empty_now;
    logic          is_full_now;
    logic [IW-1:0] head_next, head_prev, tail_next, tail_prev, scan_next;
    logic          out_free;
    logic          in_ready;
    logic          produce;
    logic          res_ok;
    logic [WORD_W-1:0] res_data;

    // Index step forward with wrap at the effective capacity.
    function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] idx,
                                               input logic [W-1:0] cap);
        logic [W-1:0] inc;
        inc = {{(W-IW){1'b0}}, idx} + W'(1);
        return (inc >= cap) ? '0 : inc[IW-1:0];
    endfunction

    // Index step backward with wrap at the effective capacity.
    function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] idx,
                                               input logic [W-1:0] cap);
        logic [W-1:0] ext;
        logic [W-1:0] dec;
        ext = {{(W-IW){1'b0}}, idx};
        dec = ((idx == '0) || (ext >= cap)) ? (cap - W'(1)) : (ext - W'(1));
        return dec[IW-1:0];
    endfunction

    // Slot storage.
    cbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Width adaptation between the 32-bit item words and the slot width.
    generate
        if (DATA_WIDTH >= WORD_W) begin : g_wide
            assign wr_data = DATA_WIDTH'(i_in_item.data_in);
            assign rd_word = ram_rdata[WORD_W-1:0];
        end else begin : g_narrow
            assign wr_data = i_in_item.data_in[DATA_WIDTH-1:0];
            assign rd_word = {{(WORD_W-DATA_WIDTH){1'b0}}, ram_rdata};
        end
    endgenerate

    // Effective capacity: zero acts as one, values above DEPTH act as DEPTH.
    always_comb begin
        if (r_cap == '0) begin
            cap_w = W'(1);
        end else if ({{(W-CNT_W){1'b0}}, r_cap} > W'(DEPTH)) begin
            cap_w = W'(DEPTH);
        end else begin
            cap_w = {{(W-CNT_W){1'b0}}, r_cap};
        end
    end

    assign is_empty_now = (r_count == '0);
    assign is_full_now  = ({{(W-CNT_W){1'b0}}, r_count} >= cap_w);

    assign head_next = idx_next(r_head, cap_w);
    assign head_prev = idx_prev(r_head, cap_w);
    assign tail_next = idx_next(r_tail, cap_w);
    assign tail_prev = idx_prev(r_tail, cap_w);
    assign scan_next = idx_next(r_scan_idx, cap_w);

    // The output register is free when empty or being taken this cycle.
    assign out_free    = !r_out_valid || i_out_ready;
    assign in_ready    = (r_state == ST_IDLE) && !i_cfg_valid && out_free;
    assign o_in_ready  = in_ready;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Next state, index updates, RAM control and result generation.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_cap       = r_cap;
        n_scan_idx  = r_scan_idx;
        n_scan_left = r_scan_left;
        n_pend      = 1'b0;
        n_key       = r_key;
        ram_we      = 1'b0;
        ram_waddr   = r_tail;
        ram_re      = 1'b0;
        ram_raddr   = r_head;
        produce     = 1'b0;
        res_ok      = 1'b0;
        res_data    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    // A capacity write also empties the deque.
                    n_cap   = i_cfg_data;
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end else if (i_in_valid && in_ready) begin
                    produce = 1'b1;
                    unique case (i_in_item.cmd)
                        CMD_PUSH_FRONT: begin
                            if (!is_full_now) begin
                                n_head    = head_prev;
                                ram_we    = 1'b1;
                                ram_waddr = head_prev;
                                n_count   = r_count + CNT_W'(1);
                                res_ok    = 1'b1;
                            end
                        end
                        CMD_PUSH_REAR: begin
                            if (!is_full_now) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_tail;
                                n_tail    = tail_next;
                                n_count   = r_count + CNT_W'(1);
                                res_ok    = 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (!is_empty_now) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_head    = head_next;
                                n_count   = r_count - CNT_W'(1);
                                produce   = 1'b0;
                                n_state   = ST_READ;
                            end
                        end
                        CMD_POP_REAR: begin
                            if (!is_empty_now) begin
                                ram_re    = 1'b1;
                                ram_raddr = tail_prev;
                                n_tail    = tail_prev;
                                n_count   = r_count - CNT_W'(1);
                                produce   = 1'b0;
                                n_state   = ST_READ;
                            end
                        end
                        CMD_PEEK_FRONT: begin
                            if (!is_empty_now) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                produce   = 1'b0;
                                n_state   = ST_READ;
                            end
                        end
                        CMD_PEEK_REAR: begin
                            if (!is_empty_now) begin
                                ram_re    = 1'b1;
                                ram_raddr = tail_prev;
                                produce   = 1'b0;
                                n_state   = ST_READ;
                            end
                        end
                        CMD_CONTAINS: begin
                            if (!is_empty_now) begin
                                n_scan_idx  = r_head;
                                n_scan_left = r_count;
                                n_key       = wr_data;
                                produce     = 1'b0;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // The slot read issued at accept is now on the RAM output.
                produce  = 1'b1;
                res_ok   = 1'b1;
                res_data = rd_word;
                n_state  = ST_IDLE;
            end
            ST_SCAN: begin
                // Issue one slot read per cycle while entries remain.
                if (r_scan_left != '0) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_scan_idx;
                    n_scan_idx  = scan_next;
                    n_scan_left = r_scan_left - CNT_W'(1);
                    n_pend      = 1'b1;
                end
                // Compare the slot read in the previous cycle.
                if (r_pend && (ram_rdata == r_key)) begin
                    produce = 1'b1;
                    res_ok  = 1'b1;
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end else if (!r_pend && (r_scan_left == '0)) begin
                    produce = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result item: status always reflects the count after the command.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (produce) begin
            n_out_valid         = 1'b1;
            n_out.ok            = res_ok;
            n_out.data_out      = res_data;
            n_out.fill_count    = n_count;
            n_out.is_empty      = (n_count == '0);
            n_out.is_full       = ({{(W-CNT_W){1'b0}}, n_count} >= cap_w);
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_scan_left <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_scan_left <= n_scan_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_scan_idx <= n_scan_idx;
        r_key      <= n_key;
        r_out      <= n_out;
    end

endmodule

### rtl/cbd_ram.sv
// ----------------------------------------------------------------------------
// cbd_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module cbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
